@@ rtl/dtp_pkg.sv @@
// Shared types and constants for the distance text parser.
// Used by dtp_step and distance_text_parser; depends on nothing else.
package dtp_pkg;

    // Parse phases
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_WHOLE = 3'd2;
    localparam logic [2:0] PH_FRAC  = 3'd3;
    localparam logic [2:0] PH_UNIT  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;
    localparam logic [2:0] PH_FAIL  = 3'd6;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UK    = 8'h4B;
    localparam logic [7:0] CH_LK    = 8'h6B;
    localparam logic [7:0] CH_NBSP1 = 8'hC2;
    localparam logic [7:0] CH_NBSP2 = 8'hA0;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [2:0]  phase;
        logic        minus;
        logic [30:0] whole;
        logic [9:0]  thou;
        logic [1:0]  fdig;
        logic [30:0] outcome;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:   PH_LEAD,
        minus:   1'b0,
        whole:   31'd0,
        thou:    10'd0,
        fdig:    2'd0,
        outcome: 31'd0
    };

endpackage

@@ rtl/dtp_step.sv @@
// Next-state and result logic of the distance text parser for one byte.
// Purely combinational; uses dtp_pkg for the state struct and codes.
module dtp_step (
    input  logic [7:0]      i_byte,
    input  dtp_pkg::t_state i_st,
    output dtp_pkg::t_state o_st,
    output logic [30:0]     o_distance_metres,
    output logic            o_parsed
);

    logic        is_digit;
    logic [3:0]  dval;
    logic [34:0] whole_x10;
    logic [30:0] whole_next;
    logic [9:0]  thou_pad;
    logic [9:0]  thou_eff;
    logic [40:0] km_full;
    logic [30:0] km_sat;
    logic        unit_skip;
    logic        unit_k;
    logic        ok;
    logic [30:0] val;

    // Decode the byte
    assign is_digit  = (i_byte >= dtp_pkg::CH_ZERO) && (i_byte <= dtp_pkg::CH_NINE);
    assign dval      = i_byte[3:0];
    assign unit_skip = (i_byte == dtp_pkg::CH_SPACE) || (i_byte == dtp_pkg::CH_TAB) ||
                       (i_byte == dtp_pkg::CH_NBSP1) || (i_byte == dtp_pkg::CH_NBSP2);
    assign unit_k    = (i_byte == dtp_pkg::CH_LK) || (i_byte == dtp_pkg::CH_UK);

    // Accumulate the whole part, saturating
    assign whole_x10  = {4'd0, i_st.whole} * 35'd10 + {31'd0, dval};
    assign whole_next = (whole_x10 > {4'd0, dtp_pkg::MAX31}) ? dtp_pkg::MAX31
                                                             : whole_x10[30:0];

    // Scale a short fraction up to thousandths
    always_comb begin
        case (i_st.fdig)
            2'd0:    thou_pad = 10'd0;
            2'd1:    thou_pad = 10'((i_st.thou << 6) + (i_st.thou << 5) + (i_st.thou << 2));
            2'd2:    thou_pad = 10'((i_st.thou << 3) + (i_st.thou << 1));
            default: thou_pad = i_st.thou;
        endcase
    end

    assign thou_eff = (i_st.phase == dtp_pkg::PH_FRAC) ? thou_pad : i_st.thou;

    // Kilometre value, saturating
    assign km_full = {10'd0, i_st.whole} * 41'd1000 + {31'd0, thou_eff};
    assign km_sat  = (km_full > {10'd0, dtp_pkg::MAX31}) ? dtp_pkg::MAX31 : km_full[30:0];

    // Result on the terminator
    always_comb begin
        val = 31'd0;
        ok  = 1'b0;
        case (i_st.phase)
            dtp_pkg::PH_WHOLE, dtp_pkg::PH_FRAC, dtp_pkg::PH_UNIT: begin
                val = i_st.whole;
                ok  = 1'b1;
            end
            dtp_pkg::PH_DONE: begin
                val = i_st.outcome;
                ok  = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (i_st.minus && (i_st.whole != 31'd0)) begin
            ok = 1'b0;
        end
        o_parsed          = ok;
        o_distance_metres = ok ? val : 31'd0;
    end

    // Advance the parse state
    always_comb begin
        o_st = i_st;
        if (i_byte == dtp_pkg::CH_NUL) begin
            o_st = dtp_pkg::ST_RESET;
        end else begin
            case (i_st.phase)
                dtp_pkg::PH_LEAD: begin
                    if (i_byte inside {dtp_pkg::CH_SPACE, [dtp_pkg::CH_TAB:dtp_pkg::CH_CR]}) begin
                        o_st.phase = dtp_pkg::PH_LEAD;
                    end else if (i_byte inside {dtp_pkg::CH_PLUS, dtp_pkg::CH_MINUS}) begin
                        o_st.minus = (i_byte == dtp_pkg::CH_MINUS);
                        o_st.phase = dtp_pkg::PH_SIGN;
                    end else if (is_digit) begin
                        o_st.whole = {27'd0, dval};
                        o_st.phase = dtp_pkg::PH_WHOLE;
                    end else begin
                        o_st.phase = dtp_pkg::PH_FAIL;
                    end
                end
                dtp_pkg::PH_SIGN: begin
                    if (is_digit) begin
                        o_st.whole = {27'd0, dval};
                        o_st.phase = dtp_pkg::PH_WHOLE;
                    end else begin
                        o_st.phase = dtp_pkg::PH_FAIL;
                    end
                end
                dtp_pkg::PH_WHOLE: begin
                    if (is_digit) begin
                        o_st.whole = whole_next;
                    end else if (i_byte inside {dtp_pkg::CH_DOT, dtp_pkg::CH_COMMA}) begin
                        o_st.thou  = 10'd0;
                        o_st.fdig  = 2'd0;
                        o_st.phase = dtp_pkg::PH_FRAC;
                    end else if (unit_skip) begin
                        o_st.phase = dtp_pkg::PH_UNIT;
                    end else begin
                        o_st.outcome = unit_k ? km_sat : i_st.whole;
                        o_st.phase   = dtp_pkg::PH_DONE;
                    end
                end
                dtp_pkg::PH_FRAC: begin
                    if (is_digit) begin
                        o_st.thou = 10'((i_st.thou << 3) + (i_st.thou << 1) + {6'd0, dval});
                        o_st.fdig = i_st.fdig + 2'd1;
                        if (i_st.fdig == 2'd2) begin
                            o_st.phase = dtp_pkg::PH_UNIT;
                        end
                    end else begin
                        // pad to three digits, then decide the unit
                        o_st.thou = thou_pad;
                        o_st.fdig = 2'd3;
                        if (unit_skip) begin
                            o_st.phase = dtp_pkg::PH_UNIT;
                        end else begin
                            o_st.outcome = unit_k ? km_sat : i_st.whole;
                            o_st.phase   = dtp_pkg::PH_DONE;
                        end
                    end
                end
                dtp_pkg::PH_UNIT: begin
                    if (unit_skip) begin
                        o_st.phase = dtp_pkg::PH_UNIT;
                    end else begin
                        o_st.outcome = unit_k ? km_sat : i_st.whole;
                        o_st.phase   = dtp_pkg::PH_DONE;
                    end
                end
                default: begin
                    // decision made or failed: drop bytes until the terminator
                    o_st = i_st;
                end
            endcase
        end
    end

endmodule

@@ rtl/distance_text_parser.sv @@
// Distance text parser top level: input register, parse state, result register.
// Depends on dtp_pkg and dtp_step.
//
// Takes one byte of text per beat and gives one result beat per zero byte:
// the distance in metres (whole part, or whole*1000+thousandths with a 'k'
// unit, saturated at 2147483647) and a parsed flag. A new byte is taken
// every cycle unless the input stalls. A byte is caught in the input
// register and passes the parse step, and a zero byte's result is then
// loaded into the result register, which offers the result beat. While a
// result beat waits under stall, the byte in the input register waits too
// and the input stalls. The saturating multiply-adds in the parse step set
// the cycle time. The parser returns to its start state after each zero
// byte.
module distance_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [30:0] o_distance_metres,
    output logic        o_parsed
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    dtp_pkg::t_state r_st;
    dtp_pkg::t_state n_st;
    logic            r_out_valid;
    logic [30:0]     r_dist;
    logic            r_parsed;
    logic [30:0]     n_dist;
    logic            n_parsed;
    logic            adv;

    // Result register free or draining this cycle
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;

    dtp_step u_step (
        .i_byte            (r_in_byte),
        .i_st              (r_st),
        .o_st              (n_st),
        .o_distance_metres (n_dist),
        .o_parsed          (n_parsed)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    // Parse state: advance on each byte that moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dtp_pkg::ST_RESET;
        end else if (r_in_valid && adv) begin
            r_st <= n_st;
        end
    end

    // Result register: load on the terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && (r_in_byte == dtp_pkg::CH_NUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid && (r_in_byte == dtp_pkg::CH_NUL)) begin
            r_dist   <= n_dist;
            r_parsed <= n_parsed;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_distance_metres = r_dist;
    assign o_parsed          = r_parsed;

endmodule

@@ tb/sv/distance_text_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for distance_text_parser: directed texts, then random texts.
// Depends on dtp_pkg and the distance_text_parser RTL; needs no files or arguments.
module distance_text_parser_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int N_ROWS      = 15;

    // One result beat: distance and parsed flag
    typedef struct packed {
        logic [30:0] metres;
        logic        ok;
    } t_reading;

    // Directed row: optional fixed expectation
    typedef struct packed {
        bit          fixed;
        logic [30:0] metres;
        logic        ok;
    } t_row_want;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [30:0] o_distance_metres;
    logic        o_parsed;

    // Predictor state, one text at a time
    logic [2:0]  text_phase;
    logic        text_minus;
    logic [30:0] text_whole;
    logic [9:0]  text_milli;
    logic [1:0]  text_mcount;
    logic [30:0] text_pick;

    t_reading    pending_readings[$];
    t_reading    head_reading;
    logic [7:0]  text_buf[$];

    int          err_count;
    int          bytes_sent;
    int          texts_sent;
    int          readings_checked;
    int          readings_parsed;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;

    // Directed texts: '~' stands for byte 0xC2 and '_' for byte 0xA0
    string dir_text [N_ROWS] = '{
        "", " \t\n12", "+7m", "-", "-3", "-0.5 k", "2147483648", "2147484k",
        "1.2345k", "3,5\tK", "9~_k", "x5", "5kzz", "0", "4."
    };
    t_row_want dir_want [N_ROWS] = '{
        '{1'b1, 31'd0, 1'b0}, '{1'b0, 31'd0, 1'b0}, '{1'b0, 31'd0, 1'b0},
        '{1'b1, 31'd0, 1'b0}, '{1'b1, 31'd0, 1'b0}, '{1'b1, 31'd500, 1'b1},
        '{1'b1, dtp_pkg::MAX31, 1'b1}, '{1'b0, 31'd0, 1'b0}, '{1'b0, 31'd0, 1'b0},
        '{1'b0, 31'd0, 1'b0}, '{1'b0, 31'd0, 1'b0}, '{1'b1, 31'd0, 1'b0},
        '{1'b0, 31'd0, 1'b0}, '{1'b1, 31'd0, 1'b1}, '{1'b0, 31'd0, 1'b0}
    };

    distance_text_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_text_byte       (i_text_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_distance_metres (o_distance_metres),
        .o_parsed          (o_parsed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clear the predictor for the next text
    function automatic void clear_text();
        text_phase  = dtp_pkg::PH_LEAD;
        text_minus  = 1'b0;
        text_whole  = '0;
        text_milli  = '0;
        text_mcount = '0;
        text_pick   = '0;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= dtp_pkg::CH_ZERO && b <= dtp_pkg::CH_NINE;
    endfunction

    // Decide the unit on a byte that follows the number
    function automatic void decide_unit(input logic [7:0] b);
        logic [63:0] wide;
        if (b == dtp_pkg::CH_SPACE || b == dtp_pkg::CH_TAB ||
            b == dtp_pkg::CH_NBSP1 || b == dtp_pkg::CH_NBSP2) begin
            text_phase = dtp_pkg::PH_UNIT;
        end else if (b == dtp_pkg::CH_LK || b == dtp_pkg::CH_UK) begin
            wide = {33'd0, text_whole} * 64'd1000 + {54'd0, text_milli};
            text_pick  = (wide > {33'd0, dtp_pkg::MAX31}) ? dtp_pkg::MAX31 : wide[30:0];
            text_phase = dtp_pkg::PH_DONE;
        end else begin
            text_pick  = text_whole;
            text_phase = dtp_pkg::PH_DONE;
        end
    endfunction

    // Advance the predictor by one byte; the reading is valid on a zero byte
    function automatic void parse_text_byte(input logic [7:0] b, output t_reading r);
        logic [63:0] wide;
        r = '0;
        if (b == dtp_pkg::CH_NUL) begin
            case (text_phase)
                dtp_pkg::PH_WHOLE, dtp_pkg::PH_FRAC, dtp_pkg::PH_UNIT: begin
                    r.metres = text_whole;
                    r.ok     = 1'b1;
                end
                dtp_pkg::PH_DONE: begin
                    r.metres = text_pick;
                    r.ok     = 1'b1;
                end
                default: r.ok = 1'b0;
            endcase
            if (text_minus && text_whole != 0) r.ok = 1'b0;
            if (!r.ok) r.metres = '0;
            clear_text();
            return;
        end
        case (text_phase)
            dtp_pkg::PH_LEAD: begin
                if (b == dtp_pkg::CH_SPACE || (b >= dtp_pkg::CH_TAB && b <= dtp_pkg::CH_CR)) begin
                    // skip white space
                end else if (b == dtp_pkg::CH_PLUS || b == dtp_pkg::CH_MINUS) begin
                    text_minus = (b == dtp_pkg::CH_MINUS);
                    text_phase = dtp_pkg::PH_SIGN;
                end else if (is_digit(b)) begin
                    text_whole = 31'(b - dtp_pkg::CH_ZERO);
                    text_phase = dtp_pkg::PH_WHOLE;
                end else begin
                    text_phase = dtp_pkg::PH_FAIL;
                end
            end
            dtp_pkg::PH_SIGN: begin
                if (is_digit(b)) begin
                    text_whole = 31'(b - dtp_pkg::CH_ZERO);
                    text_phase = dtp_pkg::PH_WHOLE;
                end else begin
                    text_phase = dtp_pkg::PH_FAIL;
                end
            end
            dtp_pkg::PH_WHOLE: begin
                if (is_digit(b)) begin
                    wide = {33'd0, text_whole} * 64'd10 + 64'(b - dtp_pkg::CH_ZERO);
                    text_whole = (wide > {33'd0, dtp_pkg::MAX31}) ? dtp_pkg::MAX31
                                                                  : wide[30:0];
                end else if (b == dtp_pkg::CH_DOT || b == dtp_pkg::CH_COMMA) begin
                    text_milli  = '0;
                    text_mcount = '0;
                    text_phase  = dtp_pkg::PH_FRAC;
                end else begin
                    decide_unit(b);
                end
            end
            dtp_pkg::PH_FRAC: begin
                if (is_digit(b)) begin
                    text_milli  = text_milli * 10'd10 + 10'(b - dtp_pkg::CH_ZERO);
                    text_mcount = text_mcount + 2'd1;
                    if (text_mcount >= 2'd3) text_phase = dtp_pkg::PH_UNIT;
                end else begin
                    // pad the fraction out to thousandths
                    while (text_mcount < 2'd3) begin
                        text_milli  = text_milli * 10'd10;
                        text_mcount = text_mcount + 2'd1;
                    end
                    decide_unit(b);
                end
            end
            dtp_pkg::PH_UNIT: decide_unit(b);
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] decode_char(input byte c);
        if (c == "~") return dtp_pkg::CH_NBSP1;
        if (c == "_") return dtp_pkg::CH_NBSP2;
        return 8'(c);
    endfunction

    // Build a random text: mostly well formed numbers, the rest noise
    function automatic void compose_text();
        int  n;
        int  pick;
        bit  zero_only;
        text_buf.delete();
        if ($urandom_range(0, 99) < 20) begin
            n = $urandom_range(0, 6);
            repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            text_buf.push_back($urandom_range(0, 1) ? dtp_pkg::CH_SPACE
                                                    : 8'(dtp_pkg::CH_TAB + $urandom_range(0, 4)));
        pick = $urandom_range(0, 9);
        if (pick < 2) text_buf.push_back(dtp_pkg::CH_PLUS);
        else if (pick < 4) text_buf.push_back(dtp_pkg::CH_MINUS);
        pick = $urandom_range(0, 99);
        if (pick < 5) n = 0;
        else if (pick < 10) n = $urandom_range(10, 12);
        else n = $urandom_range(1, 4);
        zero_only = ($urandom_range(0, 9) == 0);
        repeat (n)
            text_buf.push_back(zero_only ? dtp_pkg::CH_ZERO
                                         : 8'(dtp_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) < 4) begin
            text_buf.push_back($urandom_range(0, 1) ? dtp_pkg::CH_DOT : dtp_pkg::CH_COMMA);
            repeat ($urandom_range(0, 4))
                text_buf.push_back(8'(dtp_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: text_buf.push_back(dtp_pkg::CH_SPACE);
                1: text_buf.push_back(dtp_pkg::CH_TAB);
                2: text_buf.push_back(dtp_pkg::CH_NBSP1);
                default: text_buf.push_back(dtp_pkg::CH_NBSP2);
            endcase
        end
        case ($urandom_range(0, 3))
            0: text_buf.push_back(dtp_pkg::CH_LK);
            1: text_buf.push_back(dtp_pkg::CH_UK);
            2: text_buf.push_back(8'($urandom_range(1, 255)));
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    // Offer one beat and hold it until it is taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_text_byte = b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Send text_buf and its zero byte, and queue the expected reading
    task automatic send_text(input bit use_fixed, input t_reading fixed_reading);
        t_reading got;
        foreach (text_buf[i]) begin
            send_byte(text_buf[i]);
            parse_text_byte(text_buf[i], got);
        end
        send_byte(dtp_pkg::CH_NUL);
        parse_text_byte(dtp_pkg::CH_NUL, got);
        pending_readings.push_back(use_fixed ? fixed_reading : got);
        texts_sent++;
    endtask

    // Receiver: random stalls, and one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left   = 0;
        hold_taken  = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result beat: distance %0d parsed %0b",
                         $time, o_distance_metres, o_parsed);
                err_count++;
            end else begin
                head_reading = pending_readings.pop_front();
                if (o_distance_metres !== head_reading.metres) begin
                    $display("%0t: distance_metres expected %0d, got %0d",
                             $time, head_reading.metres, o_distance_metres);
                    err_count++;
                end
                if (o_parsed !== head_reading.ok) begin
                    $display("%0t: parsed expected %0b, got %0b",
                             $time, head_reading.ok, o_parsed);
                    err_count++;
                end
                if (head_reading.ok) readings_parsed++;
                readings_checked++;
            end
        end
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d readings outstanding",
                 $time, CYCLE_LIMIT, pending_readings.size());
        $display("distance_text_parser_tb: FAIL");
        $finish;
    end

    initial begin
        t_reading fixed;
        int       start_bytes;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_text_byte   = '0;
        err_count     = 0;
        bytes_sent    = 0;
        texts_sent    = 0;
        readings_checked = 0;
        readings_parsed  = 0;
        send_idle_pct = 29;
        recv_idle_pct = 29;
        hold_req      = 1'b0;
        clear_text();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (int r = 0; r < N_ROWS; r++) begin
            text_buf.delete();
            for (int c = 0; c < dir_text[r].len(); c++)
                text_buf.push_back(decode_char(dir_text[r][c]));
            fixed.metres = dir_want[r].metres;
            fixed.ok     = dir_want[r].ok;
            send_text(dir_want[r].fixed, fixed);
        end

        // Random texts with idling on both sides
        start_bytes = bytes_sent;
        fixed = '0;
        while (bytes_sent - start_bytes < 250) begin
            compose_text();
            send_text(1'b0, fixed);
        end
        // Stretch with no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent - start_bytes < 400) begin
            compose_text();
            send_text(1'b0, fixed);
        end
        // Hold the output off while bytes keep coming, to back the block up
        recv_idle_pct = 29;
        hold_req = 1'b1;
        repeat (30) begin
            compose_text();
            send_text(1'b0, fixed);
        end
        send_idle_pct = 29;
        while (bytes_sent - start_bytes < 620) begin
            compose_text();
            send_text(1'b0, fixed);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        // Drain, then watch for stray beats
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d text bytes in %0d texts; checked %0d readings, %0d parsed.",
                 bytes_sent, texts_sent, readings_checked, readings_parsed);
        $display("Included a %0d-cycle output hold-off and %0d mismatches.",
                 HOLD_CYCLES, err_count);
        if (err_count == 0) begin
            $display("distance_text_parser_tb: PASS");
        end else begin
            $display("distance_text_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
